// ===== rtl/core/rpc_pkg.sv =====
// ----------------------------------------------------------------------------
// rpc_pkg
// Shared types, constants and arithmetic helpers for the rectangular/polar
// CORDIC converter.
// ----------------------------------------------------------------------------
package rpc_pkg;

    // CORDIC iteration count, 8 to 24
    localparam int STAGES = 16;

    // internal widths: coordinates Q8.8 * 4096, angles Q.24 radians
    localparam int XY_W = 32;
    localparam int Z_W  = 28;
    localparam int RZ_W = 30;
    localparam int K_W  = 25;
    localparam int P_W  = XY_W + K_W;
    localparam int R_SH = 36;
    localparam int Q_W  = P_W - R_SH;

    // queue between front and back, and output queue
    localparam int Q_AW    = 1;
    localparam int Q_DEPTH = 1 << Q_AW;
    localparam int O_AW    = 1;
    localparam int O_DEPTH = 1 << O_AW;

    // form codes
    localparam logic [1:0] ACT_RECT  = 2'd0;
    localparam logic [1:0] ACT_POLAR = 2'd1;

    localparam logic signed [RZ_W-1:0] RZ_PI      = RZ_W'(52707179);
    localparam logic signed [RZ_W-1:0] RZ_NPI     = -RZ_W'(52707179);
    localparam logic signed [RZ_W-1:0] RZ_TWO_PI  = RZ_W'(105414357);
    localparam logic signed [RZ_W-1:0] RZ_FOUR_PI = RZ_W'(210828714);
    localparam logic signed [RZ_W-1:0] RZ_SIX_PI  = RZ_W'(316243071);
    localparam logic signed [Z_W-1:0]  Z_HALF_PI  = Z_W'(26353589);
    localparam logic signed [Z_W-1:0]  Z_NHALF_PI = -Z_W'(26353589);
    localparam logic signed [K_W-1:0]  GAIN_Q24   = K_W'(10188014);
    localparam logic signed [16:0]     ANG_MAX    = 17'sd25736;
    localparam logic signed [16:0]     ANG_MIN    = -17'sd25736;

    typedef enum logic [1:0] {
        K_RECT,
        K_ZERO,
        K_POLAR,
        K_BAD
    } t_kind;

    typedef struct packed {
        t_kind                   kind;
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [Z_W-1:0]   z;
        logic signed [16:0]      echo_a;
        logic signed [16:0]      echo_b;
        logic        [15:0]      aux_mag;
        logic signed [15:0]      aux_ang;
        logic                    sat_pre;
    } t_job;

    typedef struct packed {
        logic signed [16:0] x_out;
        logic signed [16:0] y_out;
        logic        [15:0] magnitude;
        logic signed [15:0] angle;
        logic               mode;
        logic               bad;
        logic               sat;
    } t_res;

    function automatic logic signed [Z_W-1:0] atan_q24(input int k);
        logic signed [Z_W-1:0] v;
        unique case (k)
            0:  v = Z_W'(13176795);
            1:  v = Z_W'(7778716);
            2:  v = Z_W'(4110060);
            3:  v = Z_W'(2086331);
            4:  v = Z_W'(1047214);
            5:  v = Z_W'(524117);
            6:  v = Z_W'(262123);
            7:  v = Z_W'(131069);
            8:  v = Z_W'(65536);
            9:  v = Z_W'(32768);
            10: v = Z_W'(16384);
            11: v = Z_W'(8192);
            12: v = Z_W'(4096);
            13: v = Z_W'(2048);
            14: v = Z_W'(1024);
            15: v = Z_W'(512);
            16: v = Z_W'(256);
            17: v = Z_W'(128);
            18: v = Z_W'(64);
            19: v = Z_W'(32);
            20: v = Z_W'(16);
            21: v = Z_W'(8);
            22: v = Z_W'(4);
            23: v = Z_W'(2);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Q8.8 value to internal coordinate (times 4096)
    function automatic logic signed [XY_W-1:0] scale_coord(input logic signed [16:0] v);
        return {{(XY_W-29){v[16]}}, v, 12'b0};
    endfunction

    // Q.24 angle to Q3.13, round half up, clamped to +-pi
    function automatic logic signed [15:0] angle_q13(input logic signed [Z_W-1:0] z);
        logic signed [Z_W:0]  t;
        logic signed [16:0]   a;
        t = {z[Z_W-1], z} + (Z_W+1)'(1024);
        a = t[Z_W-1:11];
        if (a > ANG_MAX) begin
            a = ANG_MAX;
        end else if (a < ANG_MIN) begin
            a = ANG_MIN;
        end
        return a[15:0];
    endfunction

    // one micro-rotation; rotation for polar items, vectoring otherwise
    function automatic t_job cordic_step(input t_job j, input int k);
        t_job                   r;
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        logic signed [Z_W-1:0]  at;
        logic                   ccw;
        r   = j;
        xs  = j.x;
        ys  = j.y;
        dx  = ys >>> k;
        dy  = xs >>> k;
        at  = atan_q24(k);
        ccw = (j.kind == K_POLAR) ? !j.z[Z_W-1] : j.y[XY_W-1];
        if (ccw) begin
            r.x = xs - dx;
            r.y = ys + dy;
            r.z = j.z - at;
        end else begin
            r.x = xs + dx;
            r.y = ys - dy;
            r.z = j.z + at;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/rpc_front.sv =====
// ----------------------------------------------------------------------------
// rpc_front
// Takes input words, classifies the form, reduces polar angles and does the
// quadrant pre-rotation. Two register stages, handed on to the job queue.
// ----------------------------------------------------------------------------
module rpc_front
    import rpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_action,
    input  logic signed [16:0] i_first_value,
    input  logic signed [16:0] i_second_value,
    output logic               o_job_valid,
    output t_job               o_job,
    input  logic               i_q_full
);

    logic                   f_en;
    logic                   r_v1;
    logic                   r_v2;
    t_kind                  r_kind1;
    logic signed [16:0]     r_a1;
    logic signed [16:0]     r_b1;
    logic signed [Z_W-1:0]  r_z1;
    t_job                   r_job2;

    t_kind                  n_kind1;
    logic signed [Z_W-1:0]  n_z1;
    t_job                   n_job2;

    logic signed [RZ_W-1:0] zin;
    logic signed [RZ_W-1:0] p1, p2, p3, m1, m2, m3, zr;

    assign f_en        = !r_v2 || !i_q_full;
    assign full        = !f_en;
    assign o_job_valid = r_v2;
    assign o_job       = r_job2;

    // stage 1: classify and fold the angle into [-pi, pi]
    always_comb begin
        zin = {{(RZ_W-28){i_second_value[16]}}, i_second_value, 11'b0};
        p1  = zin - RZ_TWO_PI;
        p2  = zin - RZ_FOUR_PI;
        p3  = zin - RZ_SIX_PI;
        m1  = zin + RZ_TWO_PI;
        m2  = zin + RZ_FOUR_PI;
        m3  = zin + RZ_SIX_PI;
        priority if (zin > RZ_PI) begin
            priority if (p1 <= RZ_PI) zr = p1;
            else if (p2 <= RZ_PI)     zr = p2;
            else                      zr = p3;
        end else if (zin < RZ_NPI) begin
            priority if (m1 >= RZ_NPI) zr = m1;
            else if (m2 >= RZ_NPI)     zr = m2;
            else                       zr = m3;
        end else begin
            zr = zin;
        end
        n_z1 = zr[Z_W-1:0];

        priority if (i_action == ACT_RECT) begin
            n_kind1 = (i_first_value == '0 && i_second_value == '0) ? K_ZERO : K_RECT;
        end else if (i_action == ACT_POLAR) begin
            n_kind1 = K_POLAR;
        end else begin
            n_kind1 = K_BAD;
        end
    end

    // stage 2: start vector for the CORDIC
    always_comb begin
        n_job2      = '0;
        n_job2.kind = r_kind1;
        unique case (r_kind1)
            K_RECT: begin
                n_job2.echo_a = r_a1;
                n_job2.echo_b = r_b1;
                if (!r_a1[16]) begin
                    n_job2.x = scale_coord(r_a1);
                    n_job2.y = scale_coord(r_b1);
                    n_job2.z = '0;
                end else if (!r_b1[16]) begin
                    n_job2.x = scale_coord(r_b1);
                    n_job2.y = -scale_coord(r_a1);
                    n_job2.z = Z_HALF_PI;
                end else begin
                    n_job2.x = -scale_coord(r_b1);
                    n_job2.y = scale_coord(r_a1);
                    n_job2.z = Z_NHALF_PI;
                end
            end
            K_ZERO: begin
                n_job2.echo_a = r_a1;
                n_job2.echo_b = r_b1;
            end
            K_POLAR: begin
                n_job2.aux_ang = angle_q13(r_z1);
                n_job2.sat_pre = r_a1[16];
                n_job2.aux_mag = r_a1[16] ? 16'd0 : r_a1[15:0];
                if (r_z1 > Z_HALF_PI) begin
                    n_job2.x = '0;
                    n_job2.y = scale_coord(r_a1);
                    n_job2.z = r_z1 - Z_HALF_PI;
                end else if (r_z1 < Z_NHALF_PI) begin
                    n_job2.x = '0;
                    n_job2.y = -scale_coord(r_a1);
                    n_job2.z = r_z1 + Z_HALF_PI;
                end else begin
                    n_job2.x = scale_coord(r_a1);
                    n_job2.y = '0;
                    n_job2.z = r_z1;
                end
            end
            K_BAD: begin
                n_job2.kind = K_BAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (f_en) begin
            r_v1 <= push;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_en) begin
            r_kind1 <= n_kind1;
            r_a1    <= i_first_value;
            r_b1    <= i_second_value;
            r_z1    <= n_z1;
            r_job2  <= n_job2;
        end
    end

endmodule

// ===== rtl/core/rpc_queue.sv =====
// ----------------------------------------------------------------------------
// rpc_queue
// Short job queue between the front stages and the CORDIC back end.
// ----------------------------------------------------------------------------
module rpc_queue
    import rpc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_job;
    end

endmodule

// ===== rtl/core/rpc_back.sv =====
// ----------------------------------------------------------------------------
// rpc_back
// Unrolled CORDIC pipeline, one micro-rotation per stage, then gain
// correction, rounding and clipping into the result word.
// ----------------------------------------------------------------------------
module rpc_back
    import rpc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_q_valid,
    input  t_job i_q_job,
    output logic o_q_pop,
    output logic o_res_valid,
    output t_res o_res
);

    t_job                  r_st [STAGES+1];
    logic [STAGES:0]       r_sv;
    logic                  r_pv;
    t_job                  r_pj;
    logic signed [P_W-1:0] r_px;
    logic signed [P_W-1:0] r_py;
    logic signed [15:0]    r_pang;

    logic signed [XY_W-1:0] xm;
    logic signed [P_W-1:0]  rx;
    logic signed [P_W-1:0]  ry;
    logic signed [Q_W-1:0]  qx;
    logic signed [Q_W-1:0]  qy;
    logic signed [16:0]     cx;
    logic signed [16:0]     cy;
    logic                   sx;
    logic                   sy;
    logic [15:0]            mag;
    logic                   smag;

    localparam logic signed [P_W-1:0] P_HALF  = P_W'(1) <<< (R_SH - 1);
    localparam logic signed [Q_W-1:0] Q_MAX   = Q_W'(65535);
    localparam logic signed [Q_W-1:0] Q_MIN   = -Q_W'(65536);

    assign o_q_pop = i_en && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= '0;
            r_pv <= 1'b0;
        end else if (i_en) begin
            r_sv <= {r_sv[STAGES-1:0], i_q_valid};
            r_pv <= r_sv[STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_st[0] <= i_q_job;
    end

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) r_st[k+1] <= cordic_step(r_st[k], k);
        end
    end

    // gain correction product, registered before rounding
    always_comb begin
        xm = r_st[STAGES].x;
        if (r_st[STAGES].kind == K_RECT && xm[XY_W-1]) xm = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pj   <= r_st[STAGES];
            r_px   <= P_W'(xm) * P_W'(GAIN_Q24);
            r_py   <= P_W'(r_st[STAGES].y) * P_W'(GAIN_Q24);
            r_pang <= angle_q13(r_st[STAGES].z);
        end
    end

    always_comb begin
        rx = r_px + P_HALF;
        ry = r_py + P_HALF;
        qx = rx[P_W-1:R_SH];
        qy = ry[P_W-1:R_SH];

        sx = 1'b1;
        if (qx > Q_MAX)      cx = 17'sd65535;
        else if (qx < Q_MIN) cx = -17'sd65536;
        else begin
            cx = qx[16:0];
            sx = 1'b0;
        end
        sy = 1'b1;
        if (qy > Q_MAX)      cy = 17'sd65535;
        else if (qy < Q_MIN) cy = -17'sd65536;
        else begin
            cy = qy[16:0];
            sy = 1'b0;
        end

        // magnitude product is never negative
        smag = (qx > Q_MAX);
        mag  = smag ? 16'hFFFF : qx[15:0];

        o_res = '0;
        unique case (r_pj.kind)
            K_RECT: begin
                o_res.x_out     = r_pj.echo_a;
                o_res.y_out     = r_pj.echo_b;
                o_res.magnitude = mag;
                o_res.angle     = r_pang;
                o_res.sat       = smag;
            end
            K_ZERO: begin
                o_res.x_out = r_pj.echo_a;
                o_res.y_out = r_pj.echo_b;
            end
            K_POLAR: begin
                o_res.x_out     = cx;
                o_res.y_out     = cy;
                o_res.magnitude = r_pj.aux_mag;
                o_res.angle     = r_pj.aux_ang;
                o_res.mode      = 1'b1;
                o_res.sat       = r_pj.sat_pre | sx | sy;
            end
            K_BAD: begin
                o_res.bad = 1'b1;
            end
        endcase
    end

    assign o_res_valid = r_pv;

endmodule

// ===== rtl/core/rect_polar_converter.sv =====
// ----------------------------------------------------------------------------
// rect_polar_converter
// Rectangular <-> polar conversion by a pipelined CORDIC.
// ----------------------------------------------------------------------------
// Input side is a queue write port: a word (action, first_value, second_value)
// is taken on a clock edge with push high and full low. Result side is a
// queue read port: while empty is low the oldest result sits on the o_ ports
// and is taken on an edge with pop high.
// Throughput: one word per cycle, sustained, as long as results are popped.
// Path from push to result: two front stages, the job queue, an input
// register and one register per micro-rotation of the 16-stage CORDIC,
// the gain multiply, then the output queue.
// The front stages and the CORDIC pipeline run on separate enables with a
// two-deep job queue between them. When pop is held low the two-deep output
// queue fills, the CORDIC pipeline freezes, the job queue fills and full
// rises; no word is dropped. Releasing pop restarts everything without
// bubbles.
// Reset (i_rst_n low, synchronous) empties all queues and clears the
// pipeline valid flags; outputs show empty high afterwards.
// ----------------------------------------------------------------------------
module rect_polar_converter
    import rpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_action,
    input  logic signed [16:0] i_first_value,
    input  logic signed [16:0] i_second_value,
    output logic               empty,
    input  logic               pop,
    output logic signed [16:0] o_x_out,
    output logic signed [16:0] o_y_out,
    output logic [15:0]        o_magnitude_out,
    output logic signed [15:0] o_angle_out,
    output logic               o_mode_out,
    output logic               o_bad_form,
    output logic               o_saturated
);

    logic            fj_valid;
    t_job            fj;
    logic            q_full;
    logic            q_valid;
    t_job            q_job;
    logic            q_pop;
    logic            b_en;
    logic            b_valid;
    t_res            b_res;

    t_res            r_obuf [O_DEPTH];
    logic [O_AW-1:0] r_owp;
    logic [O_AW-1:0] r_orp;
    logic [O_AW:0]   r_ocnt;
    logic            w_opush;
    logic            w_opop;
    t_res            head;

    rpc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_action       (i_action),
        .i_first_value  (i_first_value),
        .i_second_value (i_second_value),
        .o_job_valid    (fj_valid),
        .o_job          (fj),
        .i_q_full       (q_full)
    );

    rpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fj_valid),
        .i_job   (fj),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    rpc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (b_en),
        .i_q_valid   (q_valid),
        .i_q_job     (q_job),
        .o_q_pop     (q_pop),
        .o_res_valid (b_valid),
        .o_res       (b_res)
    );

    // output queue; the back end advances whenever a slot is or becomes free
    assign empty   = (r_ocnt == '0);
    assign w_opop  = pop && !empty;
    assign b_en    = (r_ocnt != (O_AW+1)'(O_DEPTH)) || w_opop;
    assign w_opush = b_en && b_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (w_opush) r_owp <= r_owp + 1'b1;
            if (w_opop)  r_orp <= r_orp + 1'b1;
            unique case ({w_opush, w_opop})
                2'b10:   r_ocnt <= r_ocnt + 1'b1;
                2'b01:   r_ocnt <= r_ocnt - 1'b1;
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_opush) r_obuf[r_owp] <= b_res;
    end

    assign head            = r_obuf[r_orp];
    assign o_x_out         = head.x_out;
    assign o_y_out         = head.y_out;
    assign o_magnitude_out = head.magnitude;
    assign o_angle_out     = head.angle;
    assign o_mode_out      = head.mode;
    assign o_bad_form      = head.bad;
    assign o_saturated     = head.sat;

    a_ocnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= (O_AW+1)'(O_DEPTH))
        else $error("output queue overfilled");

    a_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_opush && r_ocnt == (O_AW+1)'(O_DEPTH)) |-> w_opop)
        else $error("result written into a full output queue");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_opop && !w_opush) |=> (r_ocnt == $past(r_ocnt) - 1'b1))
        else $error("output count lost track of a read");

endmodule

// ===== tb/tb_rect_polar_converter.sv =====
// ----------------------------------------------------------------------------
// tb_rect_polar_converter
// Self-checking bench for the CORDIC rectangular/polar converter. Words go
// in through a push/full port and results come back through an empty/pop
// port, with random gaps on both sides. Every accepted word is converted by
// an in-bench bit-exact CORDIC and the results are compared in order.
// ----------------------------------------------------------------------------
module tb_rect_polar_converter
    import rpc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     IDLE_LIMIT  = 1000;
    localparam int     ROT_STEPS   = (STAGES > 24) ? 24 : ((STAGES < 0) ? 0 : STAGES);
    localparam int     RAND_WORDS  = 1825;
    localparam longint PI_Q24      = 52707179;
    localparam longint HALF_PI_Q24 = 26353589;
    localparam longint TWO_PI_Q24  = 105414357;
    localparam longint K_Q24       = 10188014;
    localparam longint PI_Q13      = 25736;
    localparam longint C_MAX       = 65535;
    localparam longint C_MIN       = -65536;

    // invalid form codes
    localparam logic [1:0] FORM_BAD2 = 2'd2;
    localparam logic [1:0] FORM_BAD3 = 2'd3;

    localparam longint ATAN_Q24 [0:23] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    typedef struct {
        logic [1:0]         form;
        logic signed [16:0] fv;
        logic signed [16:0] sv;
    } t_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [1:0]         i_action = '0;
    logic signed [16:0] i_first_value = '0;
    logic signed [16:0] i_second_value = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [16:0] o_x_out;
    logic signed [16:0] o_y_out;
    logic [15:0]        o_magnitude_out;
    logic signed [15:0] o_angle_out;
    logic               o_mode_out;
    logic               o_bad_form;
    logic               o_saturated;

    t_word  words_to_send[$];
    t_res   results_due[$];
    t_word  next_word;
    t_res   want;
    bit     failed = 1'b0;
    bit     calm = 1'b0;
    int     send_gap = 0;
    int     recv_gap = 0;
    int     recv_draw;
    int     idle_cycles = 0;

    rect_polar_converter uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_action        (i_action),
        .i_first_value   (i_first_value),
        .i_second_value  (i_second_value),
        .empty           (empty),
        .pop             (pop),
        .o_x_out         (o_x_out),
        .o_y_out         (o_y_out),
        .o_magnitude_out (o_magnitude_out),
        .o_angle_out     (o_angle_out),
        .o_mode_out      (o_mode_out),
        .o_bad_form      (o_bad_form),
        .o_saturated     (o_saturated)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // round half up: add half an LSB, then floor
    function automatic longint round_sh(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint to_q13(longint z);
        longint a;
        a = round_sh(z, 11);
        if (a > PI_Q13) a = PI_Q13;
        if (a < -PI_Q13) a = -PI_Q13;
        return a;
    endfunction

    function automatic longint clip_coord(longint c, output bit clipped);
        longint v;
        v = round_sh(c * K_Q24, 36);
        clipped = 1'b0;
        if (v > C_MAX) begin
            v = C_MAX;
            clipped = 1'b1;
        end
        if (v < C_MIN) begin
            v = C_MIN;
            clipped = 1'b1;
        end
        return v;
    endfunction

    function automatic t_res convert_word(logic [1:0] form, logic signed [16:0] fv,
                                          logic signed [16:0] sv);
        longint a, b, xx, yy, zz, dx, dy, xo, yo, mo, ang;
        bit     sat, bad, mode, clipped;
        int     i;
        t_res   r;
        a = fv;
        b = sv;
        xo = 0; yo = 0; mo = 0; ang = 0;
        sat = 1'b0; bad = 1'b0; mode = 1'b0;
        if (form == ACT_RECT) begin
            xo = a;
            yo = b;
            if (a != 0 || b != 0) begin
                // pre-rotate the left half-plane by a quarter turn
                if (a >= 0) begin
                    xx = a * 4096; yy = b * 4096; zz = 0;
                end else if (b >= 0) begin
                    xx = b * 4096; yy = -a * 4096; zz = HALF_PI_Q24;
                end else begin
                    xx = -b * 4096; yy = a * 4096; zz = -HALF_PI_Q24;
                end
                for (i = 0; i < ROT_STEPS; i++) begin
                    dx = yy >>> i;
                    dy = xx >>> i;
                    if (yy >= 0) begin
                        xx += dx; yy -= dy; zz += ATAN_Q24[i];
                    end else begin
                        xx -= dx; yy += dy; zz -= ATAN_Q24[i];
                    end
                end
                if (xx < 0) xx = 0;
                mo = round_sh(xx * K_Q24, 36);
                if (mo > 65535) begin
                    mo = 65535;
                    sat = 1'b1;
                end
                ang = to_q13(zz);
            end
        end else if (form == ACT_POLAR) begin
            mode = 1'b1;
            zz = b * 2048;
            while (zz > PI_Q24) zz -= TWO_PI_Q24;
            while (zz < -PI_Q24) zz += TWO_PI_Q24;
            ang = to_q13(zz);
            if (a < 0) begin
                mo = 0;
                sat = 1'b1;
            end else begin
                mo = a;
            end
            if (zz > HALF_PI_Q24) begin
                xx = 0; yy = a * 4096; zz -= HALF_PI_Q24;
            end else if (zz < -HALF_PI_Q24) begin
                xx = 0; yy = -a * 4096; zz += HALF_PI_Q24;
            end else begin
                xx = a * 4096; yy = 0;
            end
            for (i = 0; i < ROT_STEPS; i++) begin
                dx = yy >>> i;
                dy = xx >>> i;
                if (zz >= 0) begin
                    xx -= dx; yy += dy; zz -= ATAN_Q24[i];
                end else begin
                    xx += dx; yy -= dy; zz += ATAN_Q24[i];
                end
            end
            xo = clip_coord(xx, clipped);
            sat |= clipped;
            yo = clip_coord(yy, clipped);
            sat |= clipped;
        end else begin
            bad = 1'b1;
        end
        r.x_out     = xo[16:0];
        r.y_out     = yo[16:0];
        r.magnitude = mo[15:0];
        r.angle     = ang[15:0];
        r.mode      = mode;
        r.bad       = bad;
        r.sat       = sat;
        return r;
    endfunction

    function automatic logic signed [16:0] draw_value();
        case ($urandom_range(0, 5))
            3: return 17'(int'($urandom_range(0, 2047)) - 1024);
            4: begin
                case ($urandom_range(0, 3))
                    0: return -17'sd65536;
                    1: return 17'sd65535;
                    2: return 17'sd0;
                    default: return -17'sd1;
                endcase
            end
            5: return 17'(int'($urandom_range(0, 32767)) - 16384);
            default: return 17'($urandom);
        endcase
    endfunction

    task automatic queue_word(logic [1:0] form, logic signed [16:0] fv, logic signed [16:0] sv);
        t_word w;
        w.form = form;
        w.fv   = fv;
        w.sv   = sv;
        words_to_send.push_back(w);
    endtask

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            failed = 1'b1;
        end
    endtask

    // sender: one word in flight on the push port at a time
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push     <= 1'b0;
            send_gap <= 0;
        end else if (!push || !full) begin
            if (push) begin
                results_due.push_back(convert_word(i_action, i_first_value, i_second_value));
            end
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                push     <= 1'b0;
            end else if (words_to_send.size() != 0) begin
                next_word      = words_to_send.pop_front();
                i_action       <= next_word.form;
                i_first_value  <= next_word.fv;
                i_second_value <= next_word.sv;
                push           <= 1'b1;
                send_gap       <= calm ? 0 : $urandom_range(0, 3);
                if ($urandom_range(0, 99) == 0) calm <= !calm;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop      <= 1'b0;
            recv_gap <= 0;
        end else if (pop && !empty) begin
            if (results_due.size() == 0) begin
                $error("result word popped with no conversion outstanding");
                failed = 1'b1;
            end else begin
                want = results_due.pop_front();
                check_field("x_out", want.x_out, o_x_out);
                check_field("y_out", want.y_out, o_y_out);
                check_field("magnitude_out", want.magnitude, o_magnitude_out);
                check_field("angle_out", want.angle, o_angle_out);
                check_field("mode_out", want.mode, o_mode_out);
                check_field("bad_form", want.bad, o_bad_form);
                check_field("saturated", want.sat, o_saturated);
            end
            recv_draw = calm ? 0 : $urandom_range(0, 3);
            recv_gap <= recv_draw;
            pop      <= (recv_draw == 0);
        end else if (recv_gap != 0) begin
            recv_gap <= recv_gap - 1;
            pop      <= (recv_gap == 1);
        end else begin
            pop <= 1'b1;
        end
    end

    // watchdog on stalled handshakes
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int       n;
        int       pick;
        logic [1:0] form;
        // rectangular corners
        queue_word(ACT_RECT, 17'sd0, 17'sd0);
        queue_word(ACT_RECT, 17'sd65535, 17'sd65535);
        queue_word(ACT_RECT, -17'sd65536, -17'sd65536);
        queue_word(ACT_RECT, 17'sd65535, -17'sd65536);
        queue_word(ACT_RECT, -17'sd65536, 17'sd0);
        queue_word(ACT_RECT, 17'sd0, -17'sd65536);
        queue_word(ACT_RECT, -17'sd256, 17'sd256);
        queue_word(ACT_RECT, -17'sd256, -17'sd256);
        queue_word(ACT_RECT, 17'sd256, 17'sd0);
        queue_word(ACT_RECT, -17'sd1, 17'sd0);
        // polar: quadrants, wrap-round, negative length, clipping; then both invalid form codes
        queue_word(ACT_POLAR, 17'sd256, 17'sd0);
        queue_word(ACT_POLAR, 17'sd256, 17'sd12868);
        queue_word(ACT_POLAR, 17'sd256, 17'sd25736);
        queue_word(ACT_POLAR, 17'sd256, -17'sd25736);
        queue_word(ACT_POLAR, 17'sd256, 17'sd65535);
        queue_word(ACT_POLAR, 17'sd256, -17'sd65536);
        queue_word(ACT_POLAR, -17'sd256, 17'sd8192);
        queue_word(ACT_POLAR, -17'sd65536, 17'sd25736);
        queue_word(ACT_POLAR, 17'sd65535, 17'sd0);
        queue_word(ACT_POLAR, 17'sd65535, -17'sd20000);
        queue_word(ACT_POLAR, 17'sd0, 17'sd0);
        queue_word(FORM_BAD2, 17'sd1234, -17'sd1234);
        queue_word(FORM_BAD3, -17'sd65536, 17'sd65535);

        for (n = 0; n < RAND_WORDS; n++) begin
            pick = $urandom_range(0, 19);
            if (pick < 9) form = ACT_RECT;
            else if (pick < 18) form = ACT_POLAR;
            else if (pick == 18) form = FORM_BAD2;
            else form = FORM_BAD3;
            queue_word(form, draw_value(), draw_value());
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_to_send.size() != 0 || push) @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
        // allow any stray word to surface
        repeat (STAGES + 10) @(posedge i_clk);

        if (!failed && results_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== rect_polar_converter.f =====
rtl/core/rpc_pkg.sv
rtl/core/rpc_front.sv
rtl/core/rpc_queue.sv
rtl/core/rpc_back.sv
rtl/core/rect_polar_converter.sv
tb/tb_rect_polar_converter.sv
